// ===== src/buddy_allocator_defines.svh =====
// Assertion macros shared by the buddy allocator RTL.
`ifndef BUDDY_ALLOCATOR_DEFINES_SVH
`define BUDDY_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BDY_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BDY_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bdy_pkg.sv =====
// Types and codes shared by the buddy allocator modules.
package bdy_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [23:0] req_size;
        logic [47:0] address;
    } bdy_req_t;

    typedef struct packed {
        logic        ok;
        logic [47:0] block_address;
        logic [4:0]  block_log2;
        logic [23:0] used_bytes;
        logic [15:0] live_blocks;
    } bdy_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_DESC,
        S_MARK,
        S_UP_RD,
        S_UP_WR,
        S_FCHK,
        S_DONE
    } bdy_state_t;

endpackage

// ===== src/bdy_ram.sv =====
// Generic single-port RAM with registered read data.
module bdy_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/bdy_node_alu.sv =====
// Node arithmetic: merges two children's free heights and tests a node for fit.
module bdy_node_alu #(
    parameter int FR_W = 5
) (
    input  logic [FR_W-1:0] left_fr,
    input  logic [FR_W-1:0] right_fr,
    input  logic [FR_W-1:0] child_ht,
    input  logic [FR_W-1:0] node_fr,
    input  logic [FR_W-1:0] need,
    output logic [FR_W-1:0] merged_fr,
    output logic            fit
);

    logic [FR_W-1:0] full_fr;

    // A child that is wholly free carries its height plus one.
    assign full_fr = child_ht + FR_W'(1);

    always_comb
    begin
        if (left_fr == full_fr && right_fr == full_fr)
        begin
            merged_fr = child_ht + FR_W'(2);
        end
        else if (left_fr > right_fr)
        begin
            merged_fr = left_fr;
        end
        else
        begin
            merged_fr = right_fr;
        end
    end

    assign fit = (node_fr >= need);

endmodule

// ===== src/buddy_allocator.sv =====
// Buddy allocator top level: sequencer over the node memory and shared node unit.
//
// Requests arrive on in_valid/in_ready as one transaction each: an allocate
// (func 0) of req_size bytes or a free (func 1) of a block start address.
// Exactly one result transaction leaves on out_valid/out_ready per request.
// heap_base is written on cfg_valid/cfg_ready; cfg_ready is always high.
// Each node of the tree holds a taken flag and the height of the largest
// wholly free block below it, in one single-port RAM, so every step of a
// request is one access of that port. An allocate takes the rounding steps
// (one per power of two above the minimum block), one read per level on the
// way down and two accesses per level on the way back up; a free takes one
// read per level down to the block and the same walk up. A request holds the
// sequencer, with in_ready low, until its result enters the result register.
// After reset a clearing sweep writes every node, 2^(HEAP_LOG2-MIN_BLOCK_LOG2+1)-1
// of them (65535 by default), with in_ready low. The result register frees the
// sequencer: a new request is taken while a result still waits, and only the
// final hand-over of the next result stalls while out_ready stays low.
`include "buddy_allocator_defines.svh"

module buddy_allocator
    import bdy_pkg::*;
#(
    parameter int HEAP_LOG2      = 23,
    parameter int MIN_BLOCK_LOG2 = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bdy_req_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output bdy_rsp_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data
);

    localparam int TREE_DEPTH = HEAP_LOG2 - MIN_BLOCK_LOG2;
    localparam int NODE_W     = TREE_DEPTH + 1;
    localparam int NODE_COUNT = int'((longint'(1) << NODE_W) - 1);
    localparam int FR_W       = $clog2(TREE_DEPTH + 2);
    localparam int NW         = FR_W + 1;
    localparam int LG_W       = $clog2(HEAP_LOG2 + 1);
    localparam int CMP_W      = (HEAP_LOG2 + 1 > 24) ? HEAP_LOG2 + 1 : 25;

    bdy_state_t          state_reg, state_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   lvl_reg, lvl_next;
    logic [FR_W-1:0]     ht_reg, ht_next;
    logic [FR_W-1:0]     cv_reg, cv_next;
    logic [LG_W-1:0]     lg_reg, lg_next;
    logic [CMP_W-1:0]    pw_reg, pw_next;
    logic [23:0]         size_reg, size_next;
    logic [HEAP_LOG2-1:0] rel_reg, rel_next;
    logic                op_reg, op_next;
    logic                res_ok_reg, res_ok_next;
    logic [47:0]         res_addr_reg, res_addr_next;
    logic [4:0]          res_lg_reg, res_lg_next;
    logic [23:0]         used_reg, used_next;
    logic [15:0]         tally_reg, tally_next;
    logic [47:0]         base_reg;
    logic                out_valid_reg, out_valid_next;
    bdy_rsp_t            out_reg, out_next;

    logic [NODE_W-1:0]   ram_addr;
    logic                ram_we;
    logic [NW-1:0]       ram_wdata;
    logic [NW-1:0]       ram_rdata;

    logic [FR_W-1:0]     need;
    logic [FR_W-1:0]     merged_fr;
    logic                fit;
    logic                out_load;

    logic [NODE_W-1:0]   node_sel;
    logic [NODE_W-1:0]   child;
    logic [NODE_W-1:0]   parent;
    logic [47:0]         rel_full;
    logic [HEAP_LOG2:0]  one_sh;
    logic [HEAP_LOG2-1:0] low_mask;
    logic [HEAP_LOG2:0]  off_sh;
    logic [CMP_W-1:0]    blk_sh;

    bdy_ram #(
        .WIDTH(NW),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .clk  (clk),
        .addr (ram_addr),
        .we   (ram_we),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // The written child's new value is on the side its index says.
    bdy_node_alu #(
        .FR_W(FR_W)
    ) u_node_alu (
        .left_fr  (cur_reg[0] ? cv_reg : ram_rdata[FR_W-1:0]),
        .right_fr (cur_reg[0] ? ram_rdata[FR_W-1:0] : cv_reg),
        .child_ht (ht_reg),
        .node_fr  (ram_rdata[FR_W-1:0]),
        .need     (need),
        .merged_fr(merged_fr),
        .fit      (fit)
    );

    assign need      = FR_W'(lg_reg - LG_W'(MIN_BLOCK_LOG2)) + FR_W'(1);
    assign rel_full  = in_data.address - base_reg;
    assign one_sh    = (HEAP_LOG2 + 1)'(1) << lg_reg;
    assign low_mask  = one_sh[HEAP_LOG2-1:0] - HEAP_LOG2'(1);
    assign off_sh    = ((HEAP_LOG2 + 1)'(cur_reg) + (HEAP_LOG2 + 1)'(1)) << lg_reg;
    assign blk_sh    = CMP_W'(1) << lg_reg;
    assign parent    = (cur_reg - NODE_W'(1)) >> 1;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        lvl_next      = lvl_reg;
        ht_next       = ht_reg;
        cv_next       = cv_reg;
        lg_next       = lg_reg;
        pw_next       = pw_reg;
        size_next     = size_reg;
        rel_next      = rel_reg;
        op_next       = op_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        res_lg_next   = res_lg_reg;
        used_next     = used_reg;
        tally_next    = tally_reg;
        ram_addr      = cur_reg;
        ram_we        = 1'b0;
        ram_wdata     = '0;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        node_sel      = cur_reg;
        child         = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Every node starts wholly free: height plus one.
                ram_we    = 1'b1;
                ram_wdata = {1'b0, ht_reg + FR_W'(1)};
                if (cur_reg == lvl_reg)
                begin
                    ht_next  = ht_reg - FR_W'(1);
                    lvl_next = (lvl_reg << 1) + NODE_W'(2);
                end
                if (cur_reg == NODE_W'(NODE_COUNT - 1))
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + NODE_W'(1);
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = in_data.func;
                    size_next     = in_data.req_size;
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    res_lg_next   = '0;
                    cur_next      = '0;
                    ht_next       = FR_W'(TREE_DEPTH);
                    if (in_data.func == FUNC_ALLOC)
                    begin
                        if (in_data.req_size == '0 ||
                            CMP_W'(in_data.req_size) > (CMP_W'(1) << HEAP_LOG2))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            lg_next    = LG_W'(MIN_BLOCK_LOG2);
                            pw_next    = CMP_W'(1) << MIN_BLOCK_LOG2;
                            state_next = S_SIZE;
                        end
                    end
                    else if (rel_full[47:HEAP_LOG2] != '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rel_next   = rel_full[HEAP_LOG2-1:0];
                        lg_next    = LG_W'(HEAP_LOG2);
                        ram_addr   = '0;
                        state_next = S_FCHK;
                    end
                end
            end

            S_SIZE:
            begin
                if (CMP_W'(size_reg) > pw_reg)
                begin
                    lg_next = lg_reg + LG_W'(1);
                    pw_next = pw_reg << 1;
                end
                else
                begin
                    ram_addr   = '0;
                    state_next = S_DESC;
                end
            end

            S_DESC:
            begin
                // A left child that does not fit means its right sibling does.
                if (!fit && cur_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    node_sel = fit ? cur_reg : cur_reg + NODE_W'(1);
                    if (ht_reg == need - FR_W'(1))
                    begin
                        cur_next   = node_sel;
                        state_next = S_MARK;
                    end
                    else
                    begin
                        child    = (node_sel << 1) + NODE_W'(1);
                        cur_next = child;
                        ram_addr = child;
                        ht_next  = ht_reg - FR_W'(1);
                    end
                end
            end

            S_MARK:
            begin
                ram_we        = 1'b1;
                ram_wdata     = {1'b1, {FR_W{1'b0}}};
                cv_next       = '0;
                res_ok_next   = 1'b1;
                res_lg_next   = 5'(lg_reg);
                res_addr_next = base_reg + 48'(off_sh[HEAP_LOG2-1:0]);
                state_next    = S_UP_RD;
            end

            S_UP_RD:
            begin
                if (cur_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_addr   = cur_reg[0] ? cur_reg + NODE_W'(1) : cur_reg - NODE_W'(1);
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_addr   = parent;
                ram_wdata  = {1'b0, merged_fr};
                cur_next   = parent;
                ht_next    = ht_reg + FR_W'(1);
                cv_next    = merged_fr;
                state_next = S_UP_RD;
            end

            S_FCHK:
            begin
                if (ram_rdata[FR_W])
                begin
                    // The first taken node on the path must start at the address.
                    if ((rel_reg & low_mask) == '0)
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = {1'b0, ht_reg + FR_W'(1)};
                        cv_next     = ht_reg + FR_W'(1);
                        res_ok_next = 1'b1;
                        res_lg_next = 5'(lg_reg);
                        state_next  = S_UP_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (ht_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    child    = (cur_reg << 1) + NODE_W'(1)
                             + NODE_W'(rel_reg[lg_reg - LG_W'(1)]);
                    cur_next = child;
                    ram_addr = child;
                    lg_next  = lg_reg - LG_W'(1);
                    ht_next  = ht_reg - FR_W'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (res_ok_reg)
                    begin
                        if (op_reg == FUNC_ALLOC)
                        begin
                            used_next  = used_reg + blk_sh[23:0];
                            tally_next = tally_reg + 16'd1;
                        end
                        else
                        begin
                            used_next  = used_reg - blk_sh[23:0];
                            tally_next = tally_reg - 16'd1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next               = out_reg;
        out_valid_next         = out_valid_reg;
        if (out_load)
        begin
            out_valid_next         = 1'b1;
            out_next.ok            = res_ok_reg;
            out_next.block_address = res_addr_reg;
            out_next.block_log2    = res_lg_reg;
            out_next.used_bytes    = used_next;
            out_next.live_blocks   = tally_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            lvl_reg       <= '0;
            ht_reg        <= FR_W'(TREE_DEPTH);
            used_reg      <= '0;
            tally_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            lvl_reg       <= lvl_next;
            ht_reg        <= ht_next;
            used_reg      <= used_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cv_reg       <= cv_next;
        lg_reg       <= lg_next;
        pw_reg       <= pw_next;
        size_reg     <= size_next;
        rel_reg      <= rel_next;
        op_reg       <= op_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        res_lg_reg   <= res_lg_next;
        out_reg      <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BDY_ASSERT_IMP(a_fail_clean, out_valid && !out_data.ok, out_data.block_address == '0 && out_data.block_log2 == '0, "refused result carries a block")
    `BDY_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "sequencer took a second transaction at once")
    `BDY_ASSERT_IMP(a_walk_below_root, state_reg == S_UP_WR, cur_reg != '0, "parent update issued from the root")

endmodule
